### src/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// condition must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// consequent must hold whenever the antecedent holds
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### src/mhpq_pkg.sv
// shared constants, codes and types of the min-heap priority queue
`timescale 1ns / 1ps
package mhpq_pkg;

    localparam int CAPACITY   = 128;
    localparam int DIST_BITS  = 16;
    localparam int NODE_BITS  = 8;
    localparam int IDX_BITS   = $clog2(CAPACITY);
    localparam int CNT_BITS   = $clog2(CAPACITY + 1);
    localparam int CHILD_BITS = IDX_BITS + 2;

    // request codes
    localparam logic [1:0] REQ_INSERT   = 2'd0;
    localparam logic [1:0] REQ_EXTRACT  = 2'd1;
    localparam logic [1:0] REQ_DECREASE = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EX_RD,
        S_EX_LD,
        S_SU_RD,
        S_SU_CMP,
        S_SD_RD,
        S_SD_CMP_L,
        S_SD_CMP_R,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [NODE_BITS-1:0] node;
        logic [DIST_BITS-1:0] key;
    } t_entry;

    // memory access request from the sequencer
    typedef struct packed {
        logic                ren_a;
        logic [IDX_BITS-1:0] addr_a;
        logic                ren_b;
        logic [IDX_BITS-1:0] addr_b;
        logic                we;
        logic [IDX_BITS-1:0] waddr;
        t_entry              wdata;
    } t_mem_req;

    typedef struct packed {
        t_status              status;
        logic [NODE_BITS-1:0] node;
        logic [DIST_BITS-1:0] key;
        logic [CNT_BITS-1:0]  count;
    } t_result;

endpackage

### src/mhpq_store.sv
// heap slot memory: one write port, two registered read ports
`timescale 1ns / 1ps
module mhpq_store import mhpq_pkg::*; (
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_entry   o_rd_a,
    output t_entry   o_rd_b
);

    t_entry mem [CAPACITY];
    t_entry r_rd_a;
    t_entry r_rd_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // read ports hold their data while not enabled
    always_ff @(posedge i_clk) begin
        if (i_req.ren_a) begin
            r_rd_a <= mem[i_req.addr_a];
        end
        if (i_req.ren_b) begin
            r_rd_b <= mem[i_req.addr_b];
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

### src/mhpq_seq.sv
// request sequencer with the shared distance comparator
`timescale 1ns / 1ps
module mhpq_seq import mhpq_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_busy,
    input  logic [1:0]           i_req_type,
    input  logic [NODE_BITS-1:0] i_node_id,
    input  logic [DIST_BITS-1:0] i_distance,
    output t_mem_req             o_mem,
    input  t_entry               i_rd_a,
    input  t_entry               i_rd_b,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output t_result              o_res
);

    t_state                r_state;
    t_state                n_state;
    logic [CNT_BITS-1:0]   r_count;
    logic [IDX_BITS-1:0]   r_idx;
    t_entry                r_cur;
    logic [DIST_BITS-1:0]  r_best_dist;
    logic                  r_best_l;
    logic                  r_has_r;
    t_status               r_status;
    logic [NODE_BITS-1:0]  r_res_node;
    logic [DIST_BITS-1:0]  r_res_dist;

    logic                  accept;
    logic [DIST_BITS-1:0]  cmp_a;
    logic [DIST_BITS-1:0]  cmp_b;
    logic                  lt;
    logic [CHILD_BITS-1:0] left_w;
    logic [CHILD_BITS-1:0] right_w;
    logic [IDX_BITS-1:0]   parent;
    logic                  left_in;
    logic                  right_in;
    logic                  take_r;
    logic                  match;

    assign accept = i_valid && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    // child and parent slots of the current hole
    assign left_w   = CHILD_BITS'({r_idx, 1'b1});
    assign right_w  = left_w + CHILD_BITS'(1);
    assign left_in  = left_w < CHILD_BITS'(r_count);
    assign right_in = right_w < CHILD_BITS'(r_count);
    assign parent   = (r_idx - IDX_BITS'(1)) >> 1;
    assign match    = (i_rd_a.node == r_cur.node);
    assign take_r   = r_has_r && lt;

    // shared comparator, operands picked by state
    always_comb begin
        cmp_a = '0;
        cmp_b = '0;
        unique case (r_state)
            S_SU_CMP: begin
                cmp_a = r_cur.key;
                cmp_b = i_rd_a.key;
            end
            S_SD_CMP_L: begin
                cmp_a = i_rd_a.key;
                cmp_b = r_cur.key;
            end
            S_SD_CMP_R: begin
                cmp_a = i_rd_b.key;
                cmp_b = r_best_dist;
            end
            S_SCAN_CHK: begin
                cmp_a = r_cur.key;
                cmp_b = i_rd_a.key;
            end
            default: begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end
    assign lt = cmp_a < cmp_b;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_req_type)
                        REQ_INSERT:
                            n_state = (r_count >= CNT_BITS'(CAPACITY)) ? S_DONE : S_SU_RD;
                        REQ_EXTRACT:
                            n_state = (r_count == '0) ? S_DONE : S_EX_RD;
                        REQ_DECREASE:
                            n_state = (r_count == '0) ? S_DONE : S_SCAN_RD;
                        default:
                            n_state = S_DONE;
                    endcase
                end
            end
            S_EX_RD:    n_state = S_EX_LD;
            S_EX_LD:    n_state = S_SD_RD;
            S_SU_RD:    n_state = (r_idx == '0) ? S_DONE : S_SU_CMP;
            S_SU_CMP:   n_state = lt ? S_SU_RD : S_DONE;
            S_SD_RD:    n_state = left_in ? S_SD_CMP_L : S_DONE;
            S_SD_CMP_L: n_state = S_SD_CMP_R;
            S_SD_CMP_R: n_state = (take_r || r_best_l) ? S_SD_RD : S_DONE;
            S_SCAN_RD:  n_state = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (match) begin
                    n_state = lt ? S_SU_RD : S_DONE;
                end else if (r_idx == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_DONE:     n_state = i_res_ready ? S_IDLE : S_DONE;
            default:    n_state = S_IDLE;
        endcase
    end

    // memory requests and result handshake
    always_comb begin
        o_mem       = '0;
        o_res_valid = 1'b0;
        unique case (r_state)
            S_EX_RD: begin
                o_mem.ren_a  = 1'b1;
                o_mem.addr_a = '0;
                o_mem.ren_b  = 1'b1;
                o_mem.addr_b = IDX_BITS'(r_count - CNT_BITS'(1));
            end
            S_SU_RD: begin
                if (r_idx == '0) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_idx;
                    o_mem.wdata = r_cur;
                end else begin
                    o_mem.ren_a  = 1'b1;
                    o_mem.addr_a = parent;
                end
            end
            S_SU_CMP: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_idx;
                o_mem.wdata = lt ? i_rd_a : r_cur;
            end
            S_SD_RD: begin
                if (left_in) begin
                    o_mem.ren_a  = 1'b1;
                    o_mem.addr_a = IDX_BITS'(left_w);
                    o_mem.ren_b  = right_in;
                    o_mem.addr_b = IDX_BITS'(right_w);
                end else begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_idx;
                    o_mem.wdata = r_cur;
                end
            end
            S_SD_CMP_R: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_idx;
                if (take_r) begin
                    o_mem.wdata = i_rd_b;
                end else if (r_best_l) begin
                    o_mem.wdata = i_rd_a;
                end else begin
                    o_mem.wdata = r_cur;
                end
            end
            S_SCAN_RD: begin
                o_mem.ren_a  = 1'b1;
                o_mem.addr_a = r_idx;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
            end
            default: begin
                o_mem       = '0;
                o_res_valid = 1'b0;
            end
        endcase
    end

    // state and entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (accept && (i_req_type == REQ_INSERT) && (r_count < CNT_BITS'(CAPACITY))) begin
                r_count <= r_count + CNT_BITS'(1);
            end else if (r_state == S_EX_LD) begin
                r_count <= r_count - CNT_BITS'(1);
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_cur.node <= i_node_id;
                    r_cur.key  <= i_distance;
                    r_res_node <= '0;
                    r_res_dist <= '0;
                    r_status   <= ST_OK;
                    case (i_req_type)
                        REQ_INSERT: begin
                            r_idx <= IDX_BITS'(r_count);
                            if (r_count >= CNT_BITS'(CAPACITY)) begin
                                r_status <= ST_FULL;
                            end
                        end
                        REQ_EXTRACT: begin
                            if (r_count == '0) begin
                                r_status <= ST_EMPTY;
                            end
                        end
                        REQ_DECREASE: begin
                            r_idx <= IDX_BITS'(r_count - CNT_BITS'(1));
                            if (r_count == '0) begin
                                r_status <= ST_NOT_FOUND;
                            end
                        end
                        default: r_status <= ST_OK;
                    endcase
                end
            end
            S_EX_LD: begin
                r_res_node <= i_rd_a.node;
                r_res_dist <= i_rd_a.key;
                r_cur      <= i_rd_b;
                r_idx      <= '0;
            end
            S_SU_CMP: begin
                if (lt) begin
                    r_idx <= parent;
                end
            end
            S_SD_RD: begin
                r_has_r <= right_in;
            end
            S_SD_CMP_L: begin
                r_best_l    <= lt;
                r_best_dist <= lt ? i_rd_a.key : r_cur.key;
            end
            S_SD_CMP_R: begin
                if (take_r) begin
                    r_idx <= IDX_BITS'(right_w);
                end else if (r_best_l) begin
                    r_idx <= IDX_BITS'(left_w);
                end
            end
            S_SCAN_CHK: begin
                if (!match) begin
                    if (r_idx == '0) begin
                        r_status <= ST_NOT_FOUND;
                    end else begin
                        r_idx <= r_idx - IDX_BITS'(1);
                    end
                end
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    assign o_res.status = r_status;
    assign o_res.node   = r_res_node;
    assign o_res.key    = r_res_dist;
    assign o_res.count  = r_count;

endmodule

### src/min_heap_priority_queue.sv
// top level of the min-heap priority queue with its result register
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Binary min-heap of (node id, distance) pairs keyed on distance, up to
// 128 entries, held in a slot memory with one write port and two
// registered read ports. One request is worked at a time; the input
// stall stays high from acceptance until the result is loaded into the
// output register, which may still wait downstream while the next
// request is taken. An insert climbs level by level from the new last
// slot, each step reading the parent and comparing; an extract reads the
// root and the last slot, moves the last entry to the root and sinks it
// level by level; decrease-key scans slot by slot from the last live
// slot down to the match, then sifts it up if the new distance is smaller.
// The sequencer goes back to idle before the next request is taken. Each
// sift step is paced by the single shared distance comparator and the
// registered memory read. The memory needs no clearing pass after reset.
module min_heap_priority_queue import mhpq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_node_id,
    input  logic [15:0] i_distance,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_out_node_id,
    output logic [15:0] o_out_distance,
    output logic [7:0]  o_count
);

    t_mem_req mem_req;
    t_entry   rd_a;
    t_entry   rd_b;
    logic     busy;
    logic     res_valid;
    logic     res_ready;
    t_result  res;
    logic     r_out_valid;
    t_result  r_out;

    // slot memory
    mhpq_store u_store (
        .i_clk  (i_clk),
        .i_req  (mem_req),
        .o_rd_a (rd_a),
        .o_rd_b (rd_b)
    );

    // request sequencer
    mhpq_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_busy      (busy),
        .i_req_type  (i_req_type),
        .i_node_id   (i_node_id),
        .i_distance  (i_distance[DIST_BITS-1:0]),
        .o_mem       (mem_req),
        .i_rd_a      (rd_a),
        .i_rd_b      (rd_b),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign o_stall   = busy;
    assign res_ready = !r_out_valid || !i_stall;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out.status;
    assign o_out_node_id  = r_out.node;
    assign o_out_distance = r_out.key;
    assign o_count        = r_out.count;

    // result checks
    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, !o_valid || (o_count <= 8'(CAPACITY)), "count above capacity")
    `ASSERT_IMPL(a_full_count, i_clk, i_rst_n, o_valid && (o_status == ST_FULL), o_count == 8'(CAPACITY), "full with free slots")
    `ASSERT_IMPL(a_empty_count, i_clk, i_rst_n, o_valid && (o_status == ST_EMPTY), o_count == 8'd0, "empty with live entries")
    `ASSERT_IMPL(a_payload_zero, i_clk, i_rst_n, o_valid && (o_status != ST_OK), (o_out_node_id == 8'd0) && (o_out_distance == 16'd0), "payload set on failed request")

endmodule
